### sv/lgrs_pkg.sv
// ----------------------------------------------------------------------------
// lgrs_pkg
// Shared types, constants and the cell rule for the life row stepper.
// ----------------------------------------------------------------------------
package lgrs_pkg;

  localparam int DATA_W            = 64;
  localparam int ROW_W             = 6;
  localparam int DEFAULT_GRID_SIZE = 64;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PUSH_MAX    = 3;
  localparam int PUSH_W      = 2;

  // B3/S23
  localparam int NBR_W = 4;
  localparam logic [NBR_W-1:0] BIRTH_COUNT   = NBR_W'(3);
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = NBR_W'(2);

  // one column's bits as seen by its neighbors
  typedef struct packed {
    logic first;
    logic second;
    logic older;
    logic newer;
    logic cur;
  } col_bits_t;

  typedef struct packed {
    logic shift;
    logic load_first;
    logic load_second;
  } cell_ctl_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_number;
    logic [DATA_W-1:0] next_cells;
    logic              last_of_run;
  } result_t;

  // triples are {left, center, right}
  function automatic logic life_bit(input logic [2:0] above,
                                    input logic [2:0] mid,
                                    input logic [2:0] below);
    logic [NBR_W-1:0] cnt;
    cnt = NBR_W'(above[2]) + NBR_W'(above[1]) + NBR_W'(above[0])
        + NBR_W'(mid[2])   + NBR_W'(mid[0])
        + NBR_W'(below[2]) + NBR_W'(below[1]) + NBR_W'(below[0]);
    return (cnt == BIRTH_COUNT) || ((cnt == SURVIVE_COUNT) && mid[1]);
  endfunction

endpackage

### sv/lgrs_cell.sv
// ----------------------------------------------------------------------------
// lgrs_cell
// One grid column: holds the column's bits of the kept rows and computes the
// three possible next-generation bits from its own and its neighbors' bits.
// ----------------------------------------------------------------------------
module lgrs_cell (
  input  logic                clk,
  input  lgrs_pkg::cell_ctl_t ctl,
  input  logic                cur_bit,
  input  lgrs_pkg::col_bits_t left,
  input  lgrs_pkg::col_bits_t right,
  output lgrs_pkg::col_bits_t own,
  output logic                nxt_mid,
  output logic                nxt_last,
  output logic                nxt_zero
);

  logic first_r;
  logic second_r;
  logic older_r;
  logic newer_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      older_r <= newer_r;
      newer_r <= cur_bit;
    end
    if (ctl.load_first) begin
      first_r <= cur_bit;
    end
    if (ctl.load_second) begin
      second_r <= cur_bit;
    end
  end

  always_comb begin
    own.first  = first_r;
    own.second = second_r;
    own.older  = older_r;
    own.newer  = newer_r;
    own.cur    = cur_bit;
  end

  // row before last: older / newer / incoming
  assign nxt_mid = lgrs_pkg::life_bit({left.older, older_r, right.older},
                                      {left.newer, newer_r, right.newer},
                                      {left.cur,   cur_bit, right.cur});
  // last row wraps below to row 0
  assign nxt_last = lgrs_pkg::life_bit({left.newer, newer_r, right.newer},
                                       {left.cur,   cur_bit, right.cur},
                                       {left.first, first_r, right.first});
  // row 0 wraps above to the last row
  assign nxt_zero = lgrs_pkg::life_bit({left.cur,    cur_bit,  right.cur},
                                       {left.first,  first_r,  right.first},
                                       {left.second, second_r, right.second});

endmodule

### sv/lgrs_result_queue.sv
// ----------------------------------------------------------------------------
// lgrs_result_queue
// Small shifting queue of result words; takes up to three words a cycle and
// presents the oldest one from a register.
// ----------------------------------------------------------------------------
module lgrs_result_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lgrs_pkg::PUSH_W-1:0]     push_cnt,
  input  lgrs_pkg::result_t               push_items [lgrs_pkg::PUSH_MAX],
  input  logic                            head_ready,
  output logic                            head_valid,
  output lgrs_pkg::result_t               head,
  output logic [lgrs_pkg::CNT_W-1:0]      count
);

  localparam int DEPTH = lgrs_pkg::QUEUE_DEPTH;
  localparam int CW    = lgrs_pkg::CNT_W;

  lgrs_pkg::result_t q_r   [DEPTH];
  lgrs_pkg::result_t q_nxt [DEPTH];
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic [CW-1:0]     kept;
  logic              pop;

  assign pop  = head_valid && head_ready;
  assign kept = cnt_r - CW'(pop);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    // new words land right behind the ones that stay
    for (int i = 0; i < DEPTH; i++) begin
      for (int j = 0; j < lgrs_pkg::PUSH_MAX; j++) begin
        if ((push_cnt > lgrs_pkg::PUSH_W'(j)) && (CW'(i) == kept + CW'(j))) begin
          q_nxt[i] = push_items[j];
        end
      end
    end
    cnt_nxt = kept + CW'(push_cnt);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head       = q_r[0];
  assign count      = cnt_r;

endmodule

### sv/life_generation_row_stepper.sv
// ----------------------------------------------------------------------------
// life_generation_row_stepper
// One generation of B3/S23 Life on a toroidal square grid, a row at a time.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_ready / in_row_cells): rows of the current
// generation, row 0 first, one word per row; columns at GRID_SIZE and above
// are ignored.
// Output channel (out_valid / out_ready / out_row_number / out_next_cells /
// out_last_of_run): next-generation rows. Rows 0 and 1 give no word; row r
// gives next row r-1; the last row gives rows GRID_SIZE-2, GRID_SIZE-1 and
// 0, with out_last_of_run high on the final word of each input row.
// Each accepted row's words are written into the output queue, whose head
// is a register. The column cell row takes one row per cycle while in_ready
// is high, and evaluates all GRID_SIZE cells of up to three rows in parallel.
// The four-word output queue absorbs the three-word burst at frame end.
// in_ready drops only when the queue lacks room for the words that the next
// row makes, so a stalled receiver backs up into the input.
// Reset clears the queue and restarts the frame at row 0.
// ----------------------------------------------------------------------------
module life_generation_row_stepper #(
  parameter int GRID_SIZE = lgrs_pkg::DEFAULT_GRID_SIZE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lgrs_pkg::DATA_W-1:0]   in_row_cells,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lgrs_pkg::ROW_W-1:0]    out_row_number,
  output logic [lgrs_pkg::DATA_W-1:0]   out_next_cells,
  output logic                          out_last_of_run
);

  localparam int DW = lgrs_pkg::DATA_W;
  localparam int RW = lgrs_pkg::ROW_W;
  localparam int CW = lgrs_pkg::CNT_W;
  localparam int PW = lgrs_pkg::PUSH_W;
  localparam logic [RW-1:0] LAST_ROW      = RW'(GRID_SIZE - 1);
  localparam logic [RW-1:0] FIRST_ROW     = RW'(0);
  localparam logic [RW-1:0] SECOND_ROW    = RW'(1);
  localparam logic [RW-1:0] FIRST_OUT_ROW = RW'(2);
  localparam logic [PW-1:0] ONE_WORD      = PW'(1);
  localparam logic [PW-1:0] BURST_WORDS   = PW'(lgrs_pkg::PUSH_MAX);

  logic [RW-1:0]       rows_r;
  logic [RW-1:0]       rows_nxt;
  logic                accept;
  logic [PW-1:0]       need;
  logic [PW-1:0]       push_cnt;
  logic [CW-1:0]       count;
  lgrs_pkg::cell_ctl_t ctl;
  lgrs_pkg::col_bits_t col [GRID_SIZE];
  logic [DW-1:0]       row_mid;
  logic [DW-1:0]       row_last;
  logic [DW-1:0]       row_zero;
  lgrs_pkg::result_t   push_items [lgrs_pkg::PUSH_MAX];
  lgrs_pkg::result_t   head;

  // words produced by the row at the frame position
  always_comb begin
    if (rows_r == LAST_ROW) begin
      need = BURST_WORDS;
    end else if (rows_r >= FIRST_OUT_ROW) begin
      need = ONE_WORD;
    end else begin
      need = '0;
    end
  end

  assign in_ready = ((CW + 1)'(count) + (CW + 1)'(need)) <= (CW + 1)'(lgrs_pkg::QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;
  assign push_cnt = accept ? need : '0;

  always_comb begin
    rows_nxt = rows_r;
    if (accept) begin
      rows_nxt = (rows_r == LAST_ROW) ? FIRST_ROW : rows_r + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
    end else begin
      rows_r <= rows_nxt;
    end
  end

  always_comb begin
    ctl.shift       = accept;
    ctl.load_first  = accept && (rows_r == FIRST_ROW);
    ctl.load_second = accept && (rows_r == SECOND_ROW);
  end

  for (genvar k = 0; k < DW; k++) begin : g_col
    if (k < GRID_SIZE) begin : g_cell
      lgrs_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .cur_bit  (in_row_cells[k]),
        .left     (col[(k + GRID_SIZE - 1) % GRID_SIZE]),
        .right    (col[(k + 1) % GRID_SIZE]),
        .own      (col[k]),
        .nxt_mid  (row_mid[k]),
        .nxt_last (row_last[k]),
        .nxt_zero (row_zero[k])
      );
    end else begin : g_pad
      assign row_mid[k]  = 1'b0;
      assign row_last[k] = 1'b0;
      assign row_zero[k] = 1'b0;
    end
  end

  always_comb begin
    push_items[0].row_number  = rows_r - RW'(1);
    push_items[0].next_cells  = row_mid;
    push_items[0].last_of_run = (rows_r != LAST_ROW);
    push_items[1].row_number  = LAST_ROW;
    push_items[1].next_cells  = row_last;
    push_items[1].last_of_run = 1'b0;
    push_items[2].row_number  = FIRST_ROW;
    push_items[2].next_cells  = row_zero;
    push_items[2].last_of_run = 1'b1;
  end

  lgrs_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push_items (push_items),
    .head_ready (out_ready),
    .head_valid (out_valid),
    .head       (head),
    .count      (count)
  );

  assign out_row_number  = head.row_number;
  assign out_next_cells  = head.next_cells;
  assign out_last_of_run = head.last_of_run;

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(lgrs_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r <= LAST_ROW)
    else $error("row position beyond grid");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (rows_r == LAST_ROW) |=> (rows_r == FIRST_ROW) && (count >= CW'(2)))
    else $error("frame end did not restart or queue the burst");

  a_row_zero_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row_number == FIRST_ROW) |-> out_last_of_run)
    else $error("row 0 word not marked last");
`endif

endmodule
